FILE: rtl/core/wrm_pkg.sv
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared widths, payload types and status struct for the windowed running max.
// ----------------------------------------------------------------------------
package wrm_pkg;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned LAG_W       = 10;
  localparam int unsigned HW_W        = 4;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - SAMPLE_W - LAG_W;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [LAG_W-1:0]           lag_t;
  typedef logic [HW_W-1:0]            hw_t;

  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Input word, lowest field in the lowest bits.
  typedef struct packed {
    hw_t     half_width;
    lag_t    lag_high;
    lag_t    lag_low;
    sample_t sample_value;
  } in_word_t;

  // Per-sample decision from the frame tracker.
  typedef struct packed {
    logic store;
    logic emit;
    logic last;
    lag_t centre;
  } wrm_ctrl_t;

endpackage

FILE: rtl/core/wrm_frame_ctrl.sv
// ----------------------------------------------------------------------------
// wrm_frame_ctrl
// Frame index counter, latched lag range and half width, result decision.
// ----------------------------------------------------------------------------
module wrm_frame_ctrl import wrm_pkg::*; #(
  parameter int unsigned FRAME_SIZE     = 1024,
  parameter int unsigned MAX_HALF_WIDTH = 8,
  localparam int unsigned DW = $clog2(MAX_HALF_WIDTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          first_i,
  input  lag_t          lag_low_i,
  input  lag_t          lag_high_i,
  input  hw_t           half_width_i,
  output logic [DW-1:0] width_o,
  output wrm_ctrl_t     ctrl_o
);

  localparam int unsigned CW  = $clog2(FRAME_SIZE + 1);
  localparam int unsigned EWB = (CW > LAG_W + 1) ? CW : LAG_W + 1;
  localparam int unsigned EW  = EWB + 2;

  logic [CW-1:0] count_q, count_d;
  lag_t          low_q, high_q;
  logic [DW-1:0] d_q;

  logic [CW-1:0] idx;
  lag_t          low_eff, high_eff;
  logic [DW-1:0] d_sat, d_eff;
  logic [EW-1:0] idx_e, two_d, lo_bound, hi_bound, centre_e;
  logic          in_frame;

  always_comb begin
    d_sat    = (32'(half_width_i) > MAX_HALF_WIDTH) ? DW'(MAX_HALF_WIDTH)
                                                    : DW'(half_width_i);
    idx      = first_i ? '0 : count_q;
    low_eff  = first_i ? lag_low_i : low_q;
    high_eff = first_i ? lag_high_i : high_q;
    d_eff    = first_i ? d_sat : d_q;
    in_frame = (32'(idx) < FRAME_SIZE);
    idx_e    = EW'(idx);
    two_d    = EW'(d_eff) << 1;
    lo_bound = EW'(low_eff) + two_d;
    hi_bound = EW'(high_eff) + two_d;
    centre_e = idx_e - EW'(d_eff);
    count_d  = in_frame ? CW'(idx + 1'b1) : idx;
  end

  always_comb begin
    ctrl_o.store  = in_frame;
    ctrl_o.emit   = in_frame && (idx_e >= lo_bound) && (idx_e <= hi_bound);
    ctrl_o.last   = (idx_e == hi_bound);
    ctrl_o.centre = centre_e[LAG_W-1:0];
    width_o       = d_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      low_q   <= '0;
      high_q  <= '0;
      d_q     <= '0;
    end else if (step_i) begin
      count_q <= count_d;
      if (first_i) begin
        low_q  <= lag_low_i;
        high_q <= lag_high_i;
        d_q    <= d_sat;
      end
    end
  end

endmodule

FILE: rtl/core/wrm_window.sv
// ----------------------------------------------------------------------------
// wrm_window
// Shift line of recent samples and a compare tree over the active taps.
// ----------------------------------------------------------------------------
module wrm_window import wrm_pkg::*; #(
  parameter int unsigned MAX_HALF_WIDTH = 8,
  localparam int unsigned DW = $clog2(MAX_HALF_WIDTH + 1)
) (
  input  logic          clk_i,
  input  logic          shift_i,
  input  sample_t       sample_i,
  input  logic [DW-1:0] width_i,
  output sample_t       max_o
);

  localparam int unsigned TAPS   = 2 * MAX_HALF_WIDTH;
  localparam int unsigned LEAVES = 2 ** $clog2(TAPS + 1);

  sample_t taps_q [TAPS];
  sample_t node   [1:2*LEAVES-1];

  // Leaf 0 is the current sample; leaf j+1 is the sample j+1 words back.
  always_comb begin
    for (int unsigned j = 0; j < LEAVES; j++) begin
      node[LEAVES + j] = SAMPLE_MIN;
    end
    node[LEAVES] = sample_i;
    for (int unsigned j = 0; j < TAPS; j++) begin
      if (32'(j) < (32'(width_i) << 1)) begin
        node[LEAVES + 1 + j] = taps_q[j];
      end
    end
    for (int unsigned i = LEAVES - 1; i >= 1; i--) begin
      node[i] = (node[2*i] > node[2*i+1]) ? node[2*i] : node[2*i+1];
    end
  end

  assign max_o = node[1];

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      taps_q[0] <= sample_i;
      for (int unsigned j = 1; j < TAPS; j++) begin
        taps_q[j] <= taps_q[j-1];
      end
    end
  end

endmodule

FILE: rtl/core/windowed_running_max_top.sv
// ----------------------------------------------------------------------------
// windowed_running_max_top
// Sliding window maximum over one correlation frame, one sample per word.
// ----------------------------------------------------------------------------
// Path: the sample word that completes a window is held in the input register;
//   its result word is then registered in the result register for the master side.
// Throughput: one sample word per cycle; the input register and the result
//   register each advance every cycle unless the master side stalls.
// Reset: rst_ni low clears the frame counter, the held range and both valid
//   flags; the sample shift line needs no clearing.
// ----------------------------------------------------------------------------
module windowed_running_max_top import wrm_pkg::*; #(
  parameter int unsigned FRAME_SIZE     = 1024,
  parameter int unsigned MAX_HALF_WIDTH = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Slave side: sample words.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // tdata: sample_value[23:0], lag_low[33:24], lag_high[43:34], half_width[47:44]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: first_of_frame[0]
  input  logic                   s_axis_tuser_i,
  // Master side: result words.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // tdata: max_value[23:0], centre_index[33:24], zero pad[39:34]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tlast: last_of_run
  output logic                   m_axis_tlast_o
);

  localparam int unsigned DW = $clog2(MAX_HALF_WIDTH + 1);

  // Input register.
  logic     in_valid_q, in_valid_d;
  in_word_t in_word_q;
  logic     in_first_q;

  // Result register.
  logic     out_valid_q, out_valid_d;
  sample_t  out_max_q;
  lag_t     out_centre_q;
  logic     out_last_q;

  logic          advance;
  logic [DW-1:0] width;
  wrm_ctrl_t     ctrl;
  sample_t       win_max;

  // Advance the held word once the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = ctrl.emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: input fields capture on accept, result fields on an emitted advance; both hold otherwise.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_word_q  <= in_word_t'(s_axis_tdata_i);
      in_first_q <= s_axis_tuser_i;
    end
    if (advance && ctrl.emit) begin
      out_max_q    <= win_max;
      out_centre_q <= ctrl.centre;
      out_last_q   <= ctrl.last;
    end
  end

  // Track frame index and range; decide whether this sample closes a window.
  wrm_frame_ctrl #(
    .FRAME_SIZE     (FRAME_SIZE),
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_frame_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .first_i      (in_first_q),
    .lag_low_i    (in_word_q.lag_low),
    .lag_high_i   (in_word_q.lag_high),
    .half_width_i (in_word_q.half_width),
    .width_o      (width),
    .ctrl_o       (ctrl)
  );

  // Store in-frame samples and take the max over the current window.
  wrm_window #(
    .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
  ) u_window (
    .clk_i    (clk_i),
    .shift_i  (advance && ctrl.store),
    .sample_i (in_word_q.sample_value),
    .width_i  (width),
    .max_o    (win_max)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, out_centre_q, out_max_q};
  assign m_axis_tlast_o  = out_last_q;

  // Backpressure only comes from a full pipe with a stalled master side.
  a_ready_low_only_when_full : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i)
  ) else $error("slave side stalled without a full pipe");

  // A sample that closes a window always lands in the result register.
  a_emit_lands : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (advance && ctrl.emit) |=> out_valid_q
  ) else $error("emitted result lost");

  // A stalled result holds its contents.
  a_result_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=>
      (out_valid_q && $stable(out_max_q) && $stable(out_centre_q) && $stable(out_last_q))
  ) else $error("stalled result changed");

  // No sample is dropped from the input register while the pipe is blocked.
  a_input_held : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q
  ) else $error("held sample word lost");

endmodule
